### hdl/assert_macros.svh
// Assertion macros used by the checker file.
// Every check samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check with a fixed message.
`define SSC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Concurrent check with a caller message.
`define SSC_ASSERT_MSG(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

### hdl/ssc_pkg.sv
// Shared constants and types for the sphere-sphere collision block.
// No dependencies; the interfaces and the front, queue, back and top modules import this package.
`timescale 1ns / 1ps

package ssc_pkg;

    localparam int COORD_W   = 32;
    localparam int RAD_W     = 31;
    localparam int SQ_STEPS  = 32;   // one root bit per stage
    localparam int DIV_STEPS = 32;   // one quotient bit per stage
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = 2;
    localparam int Q_CW      = 3;
    // stage map of the back end: sqrt 0..32, depth, product, divide 0..32
    localparam int PD_IDX    = SQ_STEPS + 1;
    localparam int PM_IDX    = SQ_STEPS + 2;
    localparam int DV_IDX    = SQ_STEPS + 3;
    localparam int BACK_LAT  = DV_IDX + DIV_STEPS + 1;

    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX = 32'h8000_0000;

    // classified item passed from front end to back end
    typedef struct packed {
        logic             hit;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
        logic [31:0]      rsum;
        logic [63:0]      ssq;
    } ssc_item_t;

endpackage

### hdl/ssc_if.sv
// Request and response channel interfaces of the collision block.
// Depends on ssc_pkg for field widths.
`timescale 1ns / 1ps

interface ssc_req_if import ssc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] center_a_x;
    logic signed [COORD_W-1:0] center_a_y;
    logic signed [COORD_W-1:0] center_a_z;
    logic        [RAD_W-1:0]   radius_a;
    logic signed [COORD_W-1:0] center_b_x;
    logic signed [COORD_W-1:0] center_b_y;
    logic signed [COORD_W-1:0] center_b_z;
    logic        [RAD_W-1:0]   radius_b;

    modport source (output valid, center_a_x, center_a_y, center_a_z, radius_a,
                    center_b_x, center_b_y, center_b_z, radius_b, input ready);
    modport sink (input valid, center_a_x, center_a_y, center_a_z, radius_a,
                  center_b_x, center_b_y, center_b_z, radius_b, output ready);
endinterface

interface ssc_rsp_if import ssc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic signed [COORD_W-1:0] push_x;
    logic signed [COORD_W-1:0] push_y;
    logic signed [COORD_W-1:0] push_z;

    modport source (output valid, hit, push_x, push_y, push_z, input ready);
    modport sink (input valid, hit, push_x, push_y, push_z, output ready);
endinterface

### hdl/ssc_front.sv
// Front end: center differences, squares, distance-squared sum and hit test.
// Depends on ssc_pkg and ssc_req_if; four stages that move together.
`timescale 1ns / 1ps

module ssc_front import ssc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    ssc_req_if.sink   req,
    output ssc_item_t item,
    output logic      item_valid,
    input  logic      item_ready
);

    typedef struct packed {
        logic [2:0]       neg;
        logic [2:0][32:0] mag;
        logic [31:0]      rsum;
    } ssc_f1_t;

    typedef struct packed {
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
        logic             ovf;
        logic [2:0][63:0] sq;
        logic [31:0]      rsum;
        logic [63:0]      r2;
    } ssc_f2_t;

    typedef struct packed {
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
        logic             ovf;
        logic [63:0]      ssq;
        logic [31:0]      rsum;
        logic [63:0]      r2;
    } ssc_f3_t;

    ssc_f1_t   f1_reg, f1_next;
    ssc_f2_t   f2_reg, f2_next;
    ssc_f3_t   f3_reg, f3_next;
    ssc_item_t f4_reg, f4_next;
    logic [3:0] vld_reg;
    logic       en;

    logic [2:0][31:0] ca, cb;
    logic [2:0][32:0] dif;
    logic [65:0]      sum;

    assign en         = !vld_reg[3] || item_ready;
    assign req.ready  = en;
    assign item       = f4_reg;
    assign item_valid = vld_reg[3];

    always_comb
    begin
        ca = {req.center_a_z, req.center_a_y, req.center_a_x};
        cb = {req.center_b_z, req.center_b_y, req.center_b_x};
        for (int k = 0; k < 3; k++)
        begin
            dif[k] = {ca[k][31], ca[k]} - {cb[k][31], cb[k]};
            f1_next.neg[k] = dif[k][32];
            f1_next.mag[k] = dif[k][32] ? (33'd0 - dif[k]) : dif[k];
        end
        f1_next.rsum = {1'b0, req.radius_a} + {1'b0, req.radius_b};
    end

    always_comb
    begin
        f2_next.neg  = f1_reg.neg;
        f2_next.rsum = f1_reg.rsum;
        f2_next.ovf  = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            // a magnitude of 2^32 squares past 64 bits
            f2_next.ovf    = f2_next.ovf | f1_reg.mag[k][32];
            f2_next.mag[k] = f1_reg.mag[k][31:0];
            f2_next.sq[k]  = {32'd0, f1_reg.mag[k][31:0]} * {32'd0, f1_reg.mag[k][31:0]};
        end
        f2_next.r2 = {32'd0, f1_reg.rsum} * {32'd0, f1_reg.rsum};
    end

    always_comb
    begin
        sum = {2'b00, f2_reg.sq[0]} + {2'b00, f2_reg.sq[1]} + {2'b00, f2_reg.sq[2]};
        f3_next.neg  = f2_reg.neg;
        f3_next.mag  = f2_reg.mag;
        f3_next.ovf  = f2_reg.ovf | (|sum[65:64]);
        f3_next.ssq  = sum[63:0];
        f3_next.rsum = f2_reg.rsum;
        f3_next.r2   = f2_reg.r2;
    end

    always_comb
    begin
        f4_next.hit  = !f3_reg.ovf && (f3_reg.ssq < f3_reg.r2);
        f4_next.neg  = f3_reg.neg;
        f4_next.mag  = f3_reg.mag;
        f4_next.rsum = f3_reg.rsum;
        f4_next.ssq  = f3_reg.ssq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], req.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_reg <= f1_next;
            f2_reg <= f2_next;
            f3_reg <= f3_next;
            f4_reg <= f4_next;
        end
    end

endmodule

### hdl/ssc_queue.sv
// Short queue that decouples the front end from the back end.
// Depends on ssc_pkg for the item type and depth.
`timescale 1ns / 1ps

module ssc_queue import ssc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  ssc_item_t in_item,
    input  logic      in_valid,
    output logic      in_ready,
    output ssc_item_t out_item,
    output logic      out_valid,
    input  logic      out_ready
);

    ssc_item_t        mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wptr_reg, rptr_reg;
    logic [Q_CW-1:0]  cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready  = cnt_reg != Q_CW'(Q_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_item  = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_item;
        end
    end

endmodule

### hdl/ssc_back.sv
// Back end: pipelined square root, penetration depth, scaled push vector.
// Depends on ssc_pkg and ssc_rsp_if; all stages advance together.
`timescale 1ns / 1ps

module ssc_back import ssc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  ssc_item_t item,
    input  logic      item_valid,
    output logic      item_ready,
    ssc_rsp_if.source rsp
);

    typedef struct packed {
        logic             hit;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
        logic [31:0]      rsum;
        logic [63:0]      rem;
        logic [31:0]      root;
    } ssc_sq_t;

    typedef struct packed {
        logic             hit;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
        logic [31:0]      dlen;
        logic [31:0]      depth;
    } ssc_pd_t;

    typedef struct packed {
        logic             hit;
        logic [2:0]       neg;
        logic [31:0]      dlen;
        logic [2:0][63:0] prod;
    } ssc_pm_t;

    typedef struct packed {
        logic             hit;
        logic [2:0]       neg;
        logic             zero;
        logic [2:0]       big;
        logic [31:0]      dlen;
        logic [2:0][31:0] rem;
        logic [2:0][31:0] low;
        logic [2:0][31:0] quo;
    } ssc_dv_t;

    typedef struct packed {
        logic             hit;
        logic [2:0][31:0] push;
    } ssc_out_t;

    ssc_sq_t  sq_reg [SQ_STEPS+1];
    ssc_sq_t  sq_next [SQ_STEPS+1];
    ssc_pd_t  pd_reg, pd_next;
    ssc_pm_t  pm_reg, pm_next;
    ssc_dv_t  dv_reg [DIV_STEPS+1];
    ssc_dv_t  dv_next [DIV_STEPS+1];
    ssc_out_t out_reg, out_next;
    logic [BACK_LAT-1:0] vld_reg;
    logic                out_vld_reg;
    logic                en;

    logic [SQ_STEPS-1:0][65:0]  trial;
    logic [DIV_STEPS-1:0][2:0][32:0] part;

    assign en         = !out_vld_reg || rsp.ready;
    assign item_ready = en;
    assign rsp.valid  = out_vld_reg;
    assign rsp.hit    = out_reg.hit;
    assign rsp.push_x = out_reg.push[0];
    assign rsp.push_y = out_reg.push[1];
    assign rsp.push_z = out_reg.push[2];

    // square root, one result bit per stage from the top
    always_comb
    begin
        sq_next[0].hit  = item.hit;
        sq_next[0].neg  = item.neg;
        sq_next[0].mag  = item.mag;
        sq_next[0].rsum = item.rsum;
        sq_next[0].rem  = item.ssq;
        sq_next[0].root = '0;
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 4^b
            trial[k] = ({34'd0, sq_reg[k].root} << (SQ_STEPS - k))
                     + (66'd1 << (2 * (SQ_STEPS - 1 - k)));
            sq_next[k+1] = sq_reg[k];
            if ({2'b00, sq_reg[k].rem} >= trial[k])
            begin
                sq_next[k+1].rem  = sq_reg[k].rem - trial[k][63:0];
                sq_next[k+1].root = sq_reg[k].root | (32'd1 << (SQ_STEPS - 1 - k));
            end
        end
    end

    always_comb
    begin
        pd_next.hit   = sq_reg[SQ_STEPS].hit;
        pd_next.neg   = sq_reg[SQ_STEPS].neg;
        pd_next.mag   = sq_reg[SQ_STEPS].mag;
        pd_next.dlen  = sq_reg[SQ_STEPS].root;
        pd_next.depth = sq_reg[SQ_STEPS].rsum - sq_reg[SQ_STEPS].root;
    end

    always_comb
    begin
        pm_next.hit  = pd_reg.hit;
        pm_next.neg  = pd_reg.neg;
        pm_next.dlen = pd_reg.dlen;
        for (int k = 0; k < 3; k++)
        begin
            pm_next.prod[k] = {32'd0, pd_reg.mag[k]} * {32'd0, pd_reg.depth};
        end
    end

    // long division of |d| * depth by the distance, one quotient bit per stage
    always_comb
    begin
        dv_next[0].hit  = pm_reg.hit;
        dv_next[0].neg  = pm_reg.neg;
        dv_next[0].zero = pm_reg.dlen == '0;
        dv_next[0].dlen = pm_reg.dlen;
        for (int k = 0; k < 3; k++)
        begin
            // quotient of 2^32 or more saturates either way
            dv_next[0].big[k] = pm_reg.prod[k][63:32] >= pm_reg.dlen;
            dv_next[0].rem[k] = pm_reg.prod[k][63:32];
            dv_next[0].low[k] = pm_reg.prod[k][31:0];
            dv_next[0].quo[k] = '0;
        end
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            dv_next[s+1] = dv_reg[s];
            for (int k = 0; k < 3; k++)
            begin
                part[s][k] = {dv_reg[s].rem[k], dv_reg[s].low[k][31]};
                dv_next[s+1].low[k] = {dv_reg[s].low[k][30:0], 1'b0};
                if (part[s][k] >= {1'b0, dv_reg[s].dlen})
                begin
                    dv_next[s+1].rem[k] = 32'(part[s][k] - {1'b0, dv_reg[s].dlen});
                    dv_next[s+1].quo[k] = {dv_reg[s].quo[k][30:0], 1'b1};
                end
                else
                begin
                    dv_next[s+1].rem[k] = part[s][k][31:0];
                    dv_next[s+1].quo[k] = {dv_reg[s].quo[k][30:0], 1'b0};
                end
            end
        end
    end

    // sign, saturate, and drop the vector on a miss or coincident centers
    always_comb
    begin
        out_next.hit = dv_reg[DIV_STEPS].hit;
        for (int k = 0; k < 3; k++)
        begin
            if (!dv_reg[DIV_STEPS].hit || dv_reg[DIV_STEPS].zero)
            begin
                out_next.push[k] = '0;
            end
            else if (dv_reg[DIV_STEPS].neg[k])
            begin
                if (dv_reg[DIV_STEPS].big[k] || dv_reg[DIV_STEPS].quo[k] > NEG_MAX)
                begin
                    out_next.push[k] = NEG_MAX;
                end
                else
                begin
                    out_next.push[k] = 32'd0 - dv_reg[DIV_STEPS].quo[k];
                end
            end
            else
            begin
                if (dv_reg[DIV_STEPS].big[k] || dv_reg[DIV_STEPS].quo[k][31])
                begin
                    out_next.push[k] = POS_MAX;
                end
                else
                begin
                    out_next.push[k] = dv_reg[DIV_STEPS].quo[k];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[BACK_LAT-2:0], item_valid};
            out_vld_reg <= vld_reg[BACK_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= SQ_STEPS; k++)
            begin
                sq_reg[k] <= sq_next[k];
            end
            pd_reg <= pd_next;
            pm_reg <= pm_next;
            for (int s = 0; s <= DIV_STEPS; s++)
            begin
                dv_reg[s] <= dv_next[s];
            end
            out_reg <= out_next;
        end
    end

endmodule

### hdl/sphere_sphere_collision.sv
// Sphere-sphere intersection test on signed Q16.16 centers and unsigned Q15.16
// radii. A pair is taken every cycle while the result side keeps up; a result
// passes through 4 front stages, the queue, 33 square-root stages, 2
// depth/product stages, 33 divider stages and 1 output register. The stage
// count is set by the bit-per-stage square root and the bit-per-stage
// dividers. A 4-entry queue lets the front end keep taking requests while the
// back end is held by the response side.
// Depends on ssc_pkg, ssc_if, ssc_front, ssc_queue and ssc_back.
`timescale 1ns / 1ps

module sphere_sphere_collision import ssc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    ssc_req_if.sink   req,
    ssc_rsp_if.source rsp
);

    ssc_item_t f_item, b_item;
    logic      f_valid, f_ready;
    logic      b_valid, b_ready;

    ssc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .item       (f_item),
        .item_valid (f_valid),
        .item_ready (f_ready)
    );

    ssc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (f_item),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .out_item  (b_item),
        .out_valid (b_valid),
        .out_ready (b_ready)
    );

    ssc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (b_item),
        .item_valid (b_valid),
        .item_ready (b_ready),
        .rsp        (rsp)
    );

endmodule

### hdl/ssc_checker.sv
// Port-level checks on the collision block's response channel.
// Depends on assert_macros.svh; bound to sphere_sphere_collision below.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        hit,
    input logic [31:0] push_x,
    input logic [31:0] push_y,
    input logic [31:0] push_z
);

    `SSC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit) && $stable(push_x) && $stable(push_y) && $stable(push_z))
    `SSC_ASSERT_MSG(a_miss_zero, rsp_valid && !hit |-> push_x == '0 && push_y == '0 && push_z == '0, "miss with nonzero push")
    `SSC_ASSERT_MSG(a_reset_idle, $past(!rst_n) |-> !rsp_valid, "response right after reset")

endmodule

bind sphere_sphere_collision ssc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .hit       (rsp.hit),
    .push_x    (rsp.push_x),
    .push_y    (rsp.push_y),
    .push_z    (rsp.push_z)
);
